/* sv/gamq_pkg.sv */
// gamq_pkg: shared constants, types and the byte threshold table
// used by the log and search pipelines of sample_average_gamma_quantize
// no dependencies
package gamq_pkg;

	localparam int LOG_FRAC = 28;
	localparam int LOG_W = 33;   // 5-bit integer part, 28-bit fraction
	localparam int LAT_LOG = 29; // normalize stage plus one stage per fraction bit
	localparam int LAT_SRCH = 9; // difference stage plus one stage per output bit
	localparam int LAT = LAT_LOG + LAT_SRCH;

	localparam logic REG_SAMPLES = 1'b0;
	localparam logic REG_GAMMA = 1'b1;

	typedef logic [31:0] dp1_tbl_t [256];

	// q.28 log2 of a positive integer by square and compare
	function automatic logic [LOG_W-1:0] log2_const(input logic [31:0] v);
		int p;
		logic [63:0] x;
		logic [LOG_FRAC-1:0] f;
		p = 0;
		f = '0;
		for (int i = 0; i < 32; i++)
			if (v[i]) p = i;
		x = 64'(v) << (31 - p);
		for (int i = 0; i < LOG_FRAC; i++) begin
			x = (x * x) >> 31;
			f = f << 1;
			if (x[32]) begin
				x = x >> 1;
				f[0] = 1'b1;
			end
		end
		return {5'(p), f};
	endfunction

	// per byte k: 8.0 - log2(k) + one ulp, in q.28
	function automatic dp1_tbl_t dp1_build();
		dp1_tbl_t t;
		t[0] = '0;
		for (int k = 1; k < 256; k++)
			t[k] = 32'((64'd8 << LOG_FRAC) - 64'(log2_const(32'(k))) + 64'd1);
		return t;
	endfunction

	localparam dp1_tbl_t DP1_TBL = dp1_build();

endpackage

/* sv/gamq_log2.sv */
// gamq_log2: pipelined q.28 log2 of a 32-bit integer: a normalize stage, then one squaring per stage
// depends on gamq_pkg
module gamq_log2 (
	input  logic                         clk,
	input  logic                         en,
	input  logic [31:0]                  v,
	output logic [gamq_pkg::LOG_W-1:0]   lg,
	output logic                         zero
);
	import gamq_pkg::*;

	logic [31:0]         x_s [LAT_LOG];
	logic [4:0]          p_s [LAT_LOG];
	logic [LOG_FRAC-1:0] f_s [LAT_LOG];
	logic                z_s [LAT_LOG];
	logic [4:0]          lead;

	// leading one position
	always_comb begin
		lead = '0;
		for (int i = 0; i < 32; i++)
			if (v[i]) lead = 5'(i);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= v << (5'd31 - lead);
			p_s[0] <= lead;
			f_s[0] <= '0;
			z_s[0] <= (v == '0);
		end
	end

	for (genvar i = 1; i < LAT_LOG; i++) begin : g_sq
		logic [63:0] sq;
		logic [32:0] t;
		assign sq = 64'(x_s[i-1]) * 64'(x_s[i-1]);
		assign t = sq[63:31];
		always_ff @(posedge clk) begin
			if (en) begin
				x_s[i] <= t[32] ? t[32:1] : t[31:0];
				f_s[i] <= {f_s[i-1][LOG_FRAC-2:0], t[32]};
				p_s[i] <= p_s[i-1];
				z_s[i] <= z_s[i-1];
			end
		end
	end

	assign lg = {p_s[LAT_LOG-1], f_s[LAT_LOG-1]};
	assign zero = z_s[LAT_LOG-1];

endmodule

/* sv/gamq_search.sv */
// gamq_search: log difference, then an 8-stage binary search for the output byte
// depends on gamq_pkg
module gamq_search (
	input  logic                        clk,
	input  logic                        en,
	input  logic [gamq_pkg::LOG_W-1:0]  lg_sum,
	input  logic [gamq_pkg::LOG_W-1:0]  lg_n,
	input  logic                        zero,
	input  logic [15:0]                 gamma,
	output logic [7:0]                  byte_out
);
	import gamq_pkg::*;

	localparam int AW = LOG_W + 2 + 12;

	logic signed [LOG_W+1:0] l_d;
	logic [AW-1:0] a_s [LAT_SRCH];
	logic [7:0]    k_s [LAT_SRCH];
	logic          sat_s [LAT_SRCH];
	logic          z_s [LAT_SRCH];

	// l = log2(sum) - log2(n) - 16
	assign l_d = $signed({2'b00, lg_sum}) - $signed({2'b00, lg_n})
		- $signed((LOG_W+2)'(16) << LOG_FRAC);

	always_ff @(posedge clk) begin
		if (en) begin
			a_s[0] <= AW'(-l_d) << 12;
			sat_s[0] <= !l_d[LOG_W+1];
			z_s[0] <= zero;
			k_s[0] <= '0;
		end
	end

	// keep bit if floor(a / g) <= 8 - log2(cand), i.e. a < (d + 1) * g
	for (genvar i = 1; i < LAT_SRCH; i++) begin : g_bit
		logic [7:0]  cand;
		logic [47:0] prod;
		assign cand = k_s[i-1] | (8'd1 << (LAT_SRCH - 1 - i));
		assign prod = 48'(DP1_TBL[cand]) * 48'(gamma);
		always_ff @(posedge clk) begin
			if (en) begin
				k_s[i] <= (48'(a_s[i-1]) < prod) ? cand : k_s[i-1];
				a_s[i] <= a_s[i-1];
				sat_s[i] <= sat_s[i-1];
				z_s[i] <= z_s[i-1];
			end
		end
	end

	assign byte_out = z_s[LAT_SRCH-1] ? 8'd0 :
		sat_s[LAT_SRCH-1] ? 8'd255 : k_s[LAT_SRCH-1];

endmodule

/* sv/sample_average_gamma_quantize.sv */
// sample_average_gamma_quantize: top level, config registers and stall control
// depends on gamq_pkg, gamq_log2, gamq_search
//
// channel   handshake              payload
// input     in_valid / in_ready    sum_red, sum_green, sum_blue (32 bits each)
// output    out_valid / out_ready  out_red, out_green, out_blue (8 bits each)
// config    cfg_we                 cfg_index, cfg_data (16 bits)
//
// one request per cycle while the output is not stalled; a request passes through the log2
// pipeline (squaring multipliers) and then the byte search
// the whole pipeline holds when the last stage has a result not taken
// async reset clears valid bits and sets samples 1, gamma 2.0
module sample_average_gamma_quantize (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] sum_red,
	input  logic [31:0] sum_green,
	input  logic [31:0] sum_blue,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import gamq_pkg::*;

	logic [15:0]   samples_q;
	logic [15:0]   gamma_q;
	logic [LAT-1:0] vld_q;
	logic          en;
	logic [15:0]   n_eff;
	logic [15:0]   g_eff;
	logic [31:0]   sums [3];
	logic [7:0]    bytes [3];
	logic [LOG_W-1:0] lg_n;
	logic          n_zero;

	// config registers, to be written only while idle; the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_q <= 16'd1;
			gamma_q <= 16'd8192;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SAMPLES: samples_q <= cfg_data;
				REG_GAMMA:   gamma_q <= cfg_data;
				default:     ;
			endcase
		end
	end

	// zero divisor and zero gamma act as one
	assign n_eff = (samples_q == '0) ? 16'd1 : samples_q;
	assign g_eff = (gamma_q == '0) ? 16'd1 : gamma_q;

	// global stall: everything advances unless the output holds a result that is not taken
	assign en = !out_valid || out_ready;
	assign in_ready = en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[LAT-2:0], in_valid};
	end

	assign sums[0] = sum_red;
	assign sums[1] = sum_green;
	assign sums[2] = sum_blue;

	// log2 of the divisor rides alongside each pixel
	gamq_log2 u_log_n (
		.clk  (clk),
		.en   (en),
		.v    (32'(n_eff)),
		.lg   (lg_n),
		.zero (n_zero)
	);

	for (genvar c = 0; c < 3; c++) begin : g_ch
		logic [LOG_W-1:0] lg_s;
		logic             zr;
		gamq_log2 u_log (
			.clk  (clk),
			.en   (en),
			.v    (sums[c]),
			.lg   (lg_s),
			.zero (zr)
		);
		gamq_search u_srch (
			.clk      (clk),
			.en       (en),
			.lg_sum   (lg_s),
			.lg_n     (lg_n),
			.zero     (zr | n_zero),
			.gamma    (g_eff),
			.byte_out (bytes[c])
		);
	end

	assign out_red = bytes[0];
	assign out_green = bytes[1];
	assign out_blue = bytes[2];

endmodule

/* sv/gamq_checker.sv */
// gamq_checker: port-level checks for sample_average_gamma_quantize
// no dependencies; bound to the top level below
module gamq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_red,
	input logic [7:0] out_green,
	input logic [7:0] out_blue
);
	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_red)
		&& $stable(out_green) && $stable(out_blue))
		else $error("stalled result changed");

	// input side takes requests exactly when the output can move
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not follow output stall");

	// a blocked pipe with a stalled result refuses new requests
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("request taken during stall");

	// nothing comes out of an idle pipe right after reset release
	a_rst: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result valid out of reset");
endmodule

bind sample_average_gamma_quantize gamq_checker u_gamq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_red   (out_red),
	.out_green (out_green),
	.out_blue  (out_blue)
);

/* tb/sample_average_gamma_quantize_tb.sv */
// sample_average_gamma_quantize_tb: self-checking bench for the gamma quantizer
// depends on gamq_pkg and sample_average_gamma_quantize
`timescale 1ns / 100ps

module sample_average_gamma_quantize_tb;
	import gamq_pkg::*;

	localparam int CYCLE_LIMIT = 500000;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_bytes_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] sum_red;
	logic [31:0] sum_green;
	logic [31:0] sum_blue;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  out_red;
	logic [7:0]  out_green;
	logic [7:0]  out_blue;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;

	// bench copy of the two registers
	logic [15:0] spp_model;
	logic [15:0] gamma_model;

	rgb_bytes_t pending_pixels[$];
	int         error_count;
	int         cycle_count;
	bit         quiet_sender;   // no idle gaps between requests
	bit         quiet_receiver; // ready held high
	int         sink_hold;

	sample_average_gamma_quantize dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.sum_red(sum_red), .sum_green(sum_green), .sum_blue(sum_blue),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_red(out_red), .out_green(out_green), .out_blue(out_blue),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// q.28 log2 by square and compare, mantissa kept as q1.31
	function automatic longint fix_log2(input logic [31:0] v);
		int lead;
		logic [63:0] mant;
		longint frac;
		lead = 0;
		frac = 0;
		for (int i = 0; i < 32; i++)
			if (v[i]) lead = i;
		mant = 64'(v) << (31 - lead);
		for (int i = 0; i < LOG_FRAC; i++) begin
			mant = (mant * mant) >> 31;
			frac = frac << 1;
			if (mant[32]) begin
				mant = mant >> 1;
				frac = frac | 1;
			end
		end
		return (longint'(lead) << LOG_FRAC) + frac;
	endfunction

	// one channel: mean, power 1/gamma in log domain, byte by binary search
	function automatic logic [7:0] gamma_byte(input logic [31:0] s);
		logic [31:0] n;
		longint unsigned g;
		longint l;
		longint unsigned z;
		longint t;
		logic [7:0] k;
		logic [7:0] cand;
		n = {16'd0, spp_model};
		g = gamma_model;
		k = '0;
		if (s == 0) return 8'd0;
		if (n == 0) n = 1;
		if (g == 0) g = 1;
		l = fix_log2(s) - fix_log2(n) - (longint'(16) << LOG_FRAC);
		// mean of 2^16 or more clamps to full scale
		if (l >= 0) return 8'd255;
		z = (longint'(-l) * 4096) / g;
		t = (longint'(8) << LOG_FRAC) - longint'(z);
		// below one output step
		if (t < 0) return 8'd0;
		for (int bit_i = 7; bit_i >= 0; bit_i--) begin
			cand = k | (8'd1 << bit_i);
			if (fix_log2({24'd0, cand}) <= t) k = cand;
		end
		return k;
	endfunction

	// timeout watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver back pressure: mostly short stalls, now and then a long one
	always @(posedge clk or negedge arst_n) begin
		int roll;
		if (!arst_n) begin
			out_ready <= 1'b0;
			sink_hold <= 0;
		end else if (quiet_receiver) begin
			out_ready <= 1'b1;
		end else if (sink_hold > 0) begin
			out_ready <= 1'b0;
			sink_hold <= sink_hold - 1;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 15) begin
				out_ready <= 1'b0;
				sink_hold <= $urandom_range(0, 3);
			end else if (roll < 17) begin
				out_ready <= 1'b0;
				sink_hold <= $urandom_range(10, 40);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// result checker: each taken result against the oldest pending pixel
	always @(posedge clk) begin
		rgb_bytes_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected result r=%0d g=%0d b=%0d", $time,
					out_red, out_green, out_blue);
				error_count++;
			end else begin
				want = pending_pixels.pop_front();
				if (out_red !== want.r) begin
					$display("%0t: out_red expected %0d actual %0d", $time, want.r, out_red);
					error_count++;
				end
				if (out_green !== want.g) begin
					$display("%0t: out_green expected %0d actual %0d", $time,
						want.g, out_green);
					error_count++;
				end
				if (out_blue !== want.b) begin
					$display("%0t: out_blue expected %0d actual %0d", $time,
						want.b, out_blue);
					error_count++;
				end
			end
		end
	end

	// send one pixel request, with an optional idle gap ahead of it
	task automatic send_pixel(input logic [31:0] r, input logic [31:0] g,
			input logic [31:0] b);
		int gap;
		int roll;
		rgb_bytes_t want;
		gap = 0;
		if (!quiet_sender) begin
			roll = $urandom_range(0, 99);
			if (roll < 25) gap = $urandom_range(1, 3);
			else if (roll < 28) gap = $urandom_range(10, 50);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sum_red <= r;
		sum_green <= g;
		sum_blue <= b;
		want.r = gamma_byte(r);
		want.g = gamma_byte(g);
		want.b = gamma_byte(b);
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_pixels.push_back(want);
	endtask

	// drop valid and wait until every pending result has come out
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (LAT + 4) @(posedge clk);
	endtask

	// register write, only with the pipeline empty
	task automatic write_cfg(input logic idx, input logic [15:0] val);
		drain_results();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SAMPLES) spp_model = val;
		else gamma_model = val;
	endtask

	task automatic set_config(input logic [15:0] spp, input logic [15:0] gam);
		write_cfg(REG_SAMPLES, spp);
		write_cfg(REG_GAMMA, gam);
	endtask

	// sum with a random magnitude so small means show up often, plus zero sums and sums near the clamp point
	function automatic logic [31:0] rand_sum();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 5) return 32'd0;
		if (roll < 12) return {spp_model, 16'd0} + $urandom_range(0, 4) - 2;
		return $urandom >> $urandom_range(0, 31);
	endfunction

	// extremes of the sums at reset settings
	task automatic test_field_extremes();
		send_pixel(32'd0, 32'hFFFF_FFFF, 32'd1);
		send_pixel(32'hFFFF_FFFF, 32'd0, 32'h0001_0000);
		send_pixel(32'h0000_FFFF, 32'h0001_0000, 32'h0001_0001);
		send_pixel(32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000);
		send_pixel(32'h0000_0100, 32'h0000_0080, 32'h0000_8000);
	endtask

	// zero sum, clamp, below one step, zero and full-scale registers
	task automatic test_special_cases();
		set_config(16'd4, 16'd4096);
		send_pixel(32'd0, 32'h0004_0000, 32'h0003_FFFF);
		send_pixel(32'd1, 32'h0000_0400, 32'h0010_0000);
		set_config(16'd0, 16'd0);
		send_pixel(32'd1, 32'h0000_FFFF, 32'h0001_0000);
		send_pixel(32'h0000_0001, 32'h0000_0002, 32'h0000_8000);
		set_config(16'd65535, 16'd65535);
		send_pixel(32'hFFFF_FFFF, 32'd1, 32'h0000_0100);
		send_pixel(32'hFFFE_FFFF, 32'hFFFF_0000, 32'h1234_5678);
		set_config(16'd1, 16'd1);
		send_pixel(32'h0000_FFFF, 32'h0000_8000, 32'd1);
		set_config(16'd65535, 16'd1);
		send_pixel(32'hFFFF_FFFF, 32'h0001_0000, 32'd1);
	endtask

	// random pixels over a series of settings, fixed ones first, then random ones
	task automatic test_random_pixels();
		logic [15:0] spp_list[6];
		logic [15:0] gam_list[6];
		spp_list = '{16'd1, 16'd65535, 16'd1, 16'd3, 16'd0, 16'd16};
		gam_list = '{16'd8192, 16'd65535, 16'd1, 16'd9011, 16'd0, 16'd4096};
		for (int ph = 0; ph < 8; ph++) begin
			if (ph < 6) set_config(spp_list[ph], gam_list[ph]);
			else set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
			quiet_sender = (ph == 2);
			quiet_receiver = (ph == 2 || ph == 5);
			for (int i = 0; i < 205; i++) begin
				send_pixel(rand_sum(), rand_sum(), rand_sum());
				// sender waits for the pipeline to run dry once mid-phase
				if (ph == 3 && i == 100) drain_results();
			end
			quiet_sender = 1'b0;
			quiet_receiver = 1'b0;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		sum_red = '0;
		sum_green = '0;
		sum_blue = '0;
		cfg_we = 1'b0;
		cfg_index = REG_SAMPLES;
		cfg_data = '0;
		spp_model = 16'd1;
		gamma_model = 16'd8192;
		error_count = 0;
		cycle_count = 0;
		quiet_sender = 1'b0;
		quiet_receiver = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_special_cases();
		test_random_pixels();

		drain_results();
		if (error_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

/* sample_average_gamma_quantize.f */
sv/gamq_pkg.sv
sv/gamq_log2.sv
sv/gamq_search.sv
sv/sample_average_gamma_quantize.sv
sv/gamq_checker.sv
tb/sample_average_gamma_quantize_tb.sv
